// ===== rtl/msc_pkg.sv =====
// ----------------------------------------------------------------------------
// MIPS subset core package
// Shared types, codes and constants for the controller and datapath.
// ----------------------------------------------------------------------------
package msc_pkg;

  localparam int unsigned MemBytesDefault = 65536;

  typedef enum logic [2:0] {
    ACT_LOAD_INSTR = 3'd0,
    ACT_LOAD_DATA  = 3'd1,
    ACT_STEP       = 3'd2,
    ACT_READ_REG   = 3'd3,
    ACT_READ_DATA  = 3'd4
  } action_t;

  localparam logic [5:0] OpRtype  = 6'b000000;
  localparam logic [5:0] OpJump   = 6'b000010;
  localparam logic [5:0] OpBeq    = 6'b000100;
  localparam logic [5:0] OpLw     = 6'b100011;
  localparam logic [5:0] OpSw     = 6'b101011;
  localparam logic [4:0] OpRtHi   = 5'b00001;
  localparam logic [2:0] AluAddu  = 3'b001;
  localparam logic [2:0] AluSubu  = 3'b011;
  localparam logic [2:0] AluAnd   = 3'b100;
  localparam logic [2:0] AluOr    = 3'b101;
  localparam logic [2:0] AluXor   = 3'b110;
  localparam logic [2:0] AluNor   = 3'b111;
  localparam logic [31:0] HaltWord = 32'hFFFF_FFFF;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_FETCH_WAIT,
    ST_DECODE,
    ST_EXEC,
    ST_MEM,
    ST_MEM_WAIT,
    ST_WB,
    ST_READ,
    ST_OUT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;    // latch the input word
    logic ld_write;   // write a byte from the input word into a memory
    logic fetch_rd;   // read instruction byte (byte_cnt)
    logic decode;     // assemble instruction, check for the halt word
    logic exec;       // read registers, start ALU and next PC
    logic mem_rd;     // read data byte (byte_cnt)
    logic mem_wr;     // write data byte (byte_cnt)
    logic wb;         // register writeback
    logic rd_data;    // read data byte for the read action
    logic cnt_clr;
    logic cnt_inc;
    logic out_load;   // build result word
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [2:0] action;
    logic       halted;
    logic       is_jump;
    logic       is_load;
    logic       is_store;
    logic [2:0] byte_cnt;
  } dp_stat_t;

endpackage

// ===== rtl/msc_if.sv =====
// ----------------------------------------------------------------------------
// MIPS subset core channels
// Valid/ready channels carrying the input and result words.
// ----------------------------------------------------------------------------
interface msc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [15:0] mem_address;
  logic [7:0]  byte_value;
  logic [4:0]  reg_select;
  modport source (output valid, action, mem_address, byte_value, reg_select, input ready);
  modport sink (input valid, action, mem_address, byte_value, reg_select, output ready);
endinterface

interface msc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_pc;
  logic [31:0] executed_word;
  logic        halted;
  logic        reg_written;
  logic [4:0]  dest_reg;
  logic [31:0] dest_value;
  logic [31:0] read_value;
  modport source (output valid, next_pc, executed_word, halted, reg_written, dest_reg,
                  dest_value, read_value, input ready);
  modport sink (input valid, next_pc, executed_word, halted, reg_written, dest_reg,
                dest_value, read_value, output ready);
endinterface

// ===== rtl/msc_datapath.sv =====
// ----------------------------------------------------------------------------
// MIPS subset core datapath
// Byte memories, register file, ALU, program counter and result register.
// ----------------------------------------------------------------------------
module msc_datapath #(
  parameter int unsigned MEM_BYTES = msc_pkg::MemBytesDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  msc_pkg::dp_cmd_t   cmd,
  output msc_pkg::dp_stat_t  stat,
  input  logic [2:0]         in_action,
  input  logic [15:0]        in_mem_address,
  input  logic [7:0]         in_byte_value,
  input  logic [4:0]         in_reg_select,
  output logic [31:0]        next_pc,
  output logic [31:0]        executed_word,
  output logic               halted,
  output logic               reg_written,
  output logic [4:0]         dest_reg,
  output logic [31:0]        dest_value,
  output logic [31:0]        read_value
);

  localparam int unsigned AW = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;

  logic [7:0]  imem [MEM_BYTES];
  logic [7:0]  dmem [MEM_BYTES];
  logic [31:0] regs [32];

  logic [2:0]  action;
  logic [15:0] mem_address;
  logic [7:0]  byte_value;
  logic [4:0]  reg_select;
  logic [31:0] pc;
  logic [31:0] last_alu;
  logic        halt_flag;
  logic [31:0] instr;
  logic [7:0]  imem_q;
  logic [7:0]  dmem_q;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [31:0] alu_res;
  logic [31:0] load_word;
  logic [2:0]  byte_cnt;
  logic [31:0] rd_val;
  logic        wen_q;
  logic        exec_d;
  logic        fetched;

  logic [5:0]  opc;
  logic [4:0]  rs, rt, rd;
  logic [31:0] imm;
  logic        is_itype, is_load, is_store, is_jump, is_branch;
  logic [2:0]  aluop;
  logic [31:0] alu_b;
  logic [31:0] alu_next;
  logic [31:0] pc4;
  logic [AW-1:0] mem_addr_w;
  logic [AW-1:0] pc_addr;
  logic [AW-1:0] data_addr;
  logic [31:0] wb_val;
  logic        wb_en;
  logic [4:0]  wb_dest;

  assign opc       = instr[31:26];
  assign rs        = instr[25:21];
  assign rt        = instr[20:16];
  assign rd        = instr[15:11];
  assign imm       = {{16{instr[15]}}, instr[15:0]};
  assign is_load   = (opc == msc_pkg::OpLw);
  assign is_store  = (opc == msc_pkg::OpSw);
  assign is_jump   = (opc == msc_pkg::OpJump);
  assign is_branch = (opc == msc_pkg::OpBeq);
  assign is_itype  = (opc != msc_pkg::OpRtype) && (opc[5:1] != msc_pkg::OpRtHi);
  assign pc4       = pc + 32'd4;
  assign mem_addr_w = mem_address[AW-1:0];
  assign pc_addr   = pc[AW-1:0] + AW'(byte_cnt[1:0]);
  assign data_addr = alu_res[AW-1:0] + AW'(byte_cnt[1:0]);

  always_comb begin
    priority if (is_load || is_store) begin
      aluop = msc_pkg::AluAddu;
    end else if (opc == msc_pkg::OpRtype) begin
      aluop = instr[2:0];
    end else begin
      aluop = opc[2:0];
    end
    alu_b = is_itype ? imm : op_b;
    unique case (aluop)
      msc_pkg::AluAddu: alu_next = op_a + alu_b;
      msc_pkg::AluSubu: alu_next = op_a - alu_b;
      msc_pkg::AluAnd:  alu_next = op_a & alu_b;
      msc_pkg::AluOr:   alu_next = op_a | alu_b;
      msc_pkg::AluXor:  alu_next = op_a ^ alu_b;
      msc_pkg::AluNor:  alu_next = ~(op_a | alu_b);
      default:          alu_next = last_alu;
    endcase
    wb_val  = is_load ? {load_word[23:0], dmem_q} : alu_res;
    wb_en   = is_itype ? !(is_store || is_branch) : 1'b1;
    wb_dest = is_itype ? rt : rd;
  end

  assign stat = '{action: action, halted: halt_flag, is_jump: is_jump,
                  is_load: is_load, is_store: is_store, byte_cnt: byte_cnt};

  // Memories: one write and one read port each, registered read data.
  always_ff @(posedge clk) begin
    if (cmd.ld_write && action == msc_pkg::ACT_LOAD_INSTR) begin
      imem[mem_addr_w] <= byte_value;
    end
    imem_q <= imem[pc_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_write && action == msc_pkg::ACT_LOAD_DATA) begin
      dmem[mem_addr_w] <= byte_value;
    end else if (cmd.mem_wr) begin
      unique case (byte_cnt[1:0])
        2'd0: dmem[data_addr] <= op_b[31:24];
        2'd1: dmem[data_addr] <= op_b[23:16];
        2'd2: dmem[data_addr] <= op_b[15:8];
        default: dmem[data_addr] <= op_b[7:0];
      endcase
    end
    dmem_q <= dmem[cmd.rd_data ? mem_addr_w : data_addr];
  end

  // Input word, byte assembly and operands.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      action      <= in_action;
      mem_address <= in_mem_address;
      byte_value  <= in_byte_value;
      reg_select  <= in_reg_select;
    end
    // Bytes arrive in the cycle after their read was issued; the counter has moved on.
    if (cmd.fetch_rd && byte_cnt != 3'd0) begin
      instr <= {instr[23:0], imem_q};
    end
    if (cmd.decode) begin
      instr <= {instr[23:0], imem_q};
    end
    if (cmd.mem_rd && byte_cnt != 3'd0) begin
      load_word <= {load_word[23:0], dmem_q};
    end
    if (cmd.exec) begin
      op_a    <= regs[rs];
      op_b    <= regs[rt];
    end
    if (cmd.out_load) begin
      next_pc       <= pc;
      halted        <= halt_flag;
      executed_word <= fetched ? instr : 32'd0;
      reg_written   <= wen_q;
      read_value    <= rd_val;
    end
  end

  // The operands are registered in the execute cycle, so the ALU result and
  // the new PC are taken in the following cycle; a jump sets the PC directly instead.
  always_ff @(posedge clk) begin
    if (rst) begin
      exec_d <= 1'b0;
    end else begin
      exec_d <= cmd.exec && !is_jump;
    end
  end

  // Whether this step fetched a word (steps while halted fetch nothing).
  always_ff @(posedge clk) begin
    if (rst || cmd.capture) begin
      fetched <= 1'b0;
    end else if (cmd.decode) begin
      fetched <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= '0;
      last_alu  <= '0;
      halt_flag <= 1'b0;
      byte_cnt  <= '0;
      wen_q     <= 1'b0;
      for (int i = 0; i < 32; i++) begin
        regs[i] <= '0;
      end
    end else begin
      if (cmd.cnt_clr) begin
        byte_cnt <= '0;
      end else if (cmd.cnt_inc) begin
        byte_cnt <= byte_cnt + 3'd1;
      end
      if (cmd.decode && {instr[23:0], imem_q} == msc_pkg::HaltWord) begin
        halt_flag <= 1'b1;
      end
      if (cmd.capture) begin
        wen_q      <= 1'b0;
        dest_reg   <= '0;
        dest_value <= '0;
      end
      if (exec_d) begin
        alu_res  <= alu_next;
        last_alu <= alu_next;
        pc <= (is_branch && op_a == op_b) ? pc4 + {imm[29:0], 2'b00} : pc4;
      end
      if (cmd.exec && is_jump) begin
        pc <= {pc4[31:28], instr[25:0], 2'b00};
      end
      if (cmd.wb) begin
        if (wb_en && wb_dest != 5'd0) begin
          regs[wb_dest] <= wb_val;
          wen_q         <= 1'b1;
          dest_reg      <= wb_dest;
          dest_value    <= wb_val;
        end
      end
    end
  end

  always_comb begin
    unique case (action)
      msc_pkg::ACT_READ_REG:  rd_val = regs[reg_select];
      msc_pkg::ACT_READ_DATA: rd_val = {24'd0, dmem_q};
      default:                rd_val = '0;
    endcase
  end

endmodule

// ===== rtl/msc_controller.sv =====
// ----------------------------------------------------------------------------
// MIPS subset core controller
// Sequences fetch, decode, execute, memory access and writeback per word.
// ----------------------------------------------------------------------------
module msc_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  msc_pkg::dp_stat_t  stat,
  output msc_pkg::dp_cmd_t   cmd
);

  msc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= msc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      msc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          cmd.cnt_clr = 1'b1;
          state_next  = msc_pkg::ST_FETCH;
        end
      end
      msc_pkg::ST_FETCH: begin
        priority case (stat.action)
          msc_pkg::ACT_STEP: state_next = stat.halted ? msc_pkg::ST_READ
                                                      : msc_pkg::ST_FETCH_WAIT;
          msc_pkg::ACT_LOAD_INSTR, msc_pkg::ACT_LOAD_DATA: begin
            cmd.ld_write = 1'b1;
            state_next   = msc_pkg::ST_READ;
          end
          default: begin
            cmd.rd_data = 1'b1;
            state_next  = msc_pkg::ST_READ;
          end
        endcase
      end
      msc_pkg::ST_FETCH_WAIT: begin
        // Four instruction-byte reads; each byte lands in the following cycle.
        cmd.fetch_rd = 1'b1;
        cmd.cnt_inc  = 1'b1;
        if (stat.byte_cnt == 3'd3) begin
          state_next = msc_pkg::ST_DECODE;
        end
      end
      msc_pkg::ST_DECODE: begin
        cmd.decode  = 1'b1;
        cmd.cnt_clr = 1'b1;
        state_next  = msc_pkg::ST_EXEC;
      end
      msc_pkg::ST_EXEC: begin
        if (stat.halted) begin
          state_next = msc_pkg::ST_READ;
        end else begin
          cmd.exec   = 1'b1;
          state_next = msc_pkg::ST_MEM;
        end
      end
      msc_pkg::ST_MEM: begin
        // ALU result settles this cycle.
        if (stat.is_jump) begin
          state_next = msc_pkg::ST_READ;
        end else if (stat.is_load || stat.is_store) begin
          state_next = msc_pkg::ST_MEM_WAIT;
        end else begin
          state_next = msc_pkg::ST_WB;
        end
      end
      msc_pkg::ST_MEM_WAIT: begin
        cmd.mem_rd  = stat.is_load;
        cmd.mem_wr  = stat.is_store;
        cmd.cnt_inc = 1'b1;
        if (stat.byte_cnt == 3'd3) begin
          state_next = msc_pkg::ST_WB;
        end
      end
      msc_pkg::ST_WB: begin
        cmd.wb     = 1'b1;
        state_next = msc_pkg::ST_READ;
      end
      msc_pkg::ST_READ: begin
        cmd.out_load = 1'b1;
        state_next   = msc_pkg::ST_OUT;
      end
      msc_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = msc_pkg::ST_IDLE;
        end
      end
      default: state_next = msc_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/mips_subset_single_cycle_core.sv =====
// ----------------------------------------------------------------------------
// MIPS subset core top level
// Multicycle core executing one architectural action per input word.
// ----------------------------------------------------------------------------
// Each input word is one action: load an instruction or data byte, execute
// one instruction, or read back a register or data byte; exactly one result
// word follows each. A step fetches, decodes and executes; lw and sw then
// access four data bytes, and all but j go through writeback. A fetched halt
// word ends the step before execution; a step while halted fetches nothing.
// The instruction and data memories each have one write and one read port,
// and the four instruction bytes and the four data bytes are each accessed
// one per cycle. A new word is taken only after the previous result has been delivered.
module mips_subset_single_cycle_core #(
  parameter int unsigned MEM_BYTES = msc_pkg::MemBytesDefault
) (
  input  logic      clk,
  input  logic      rst,
  msc_in_if.sink    in_ch,
  msc_out_if.source out_ch
);

  msc_pkg::dp_cmd_t  cmd;
  msc_pkg::dp_stat_t stat;

  msc_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  msc_datapath #(.MEM_BYTES(MEM_BYTES)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .in_action      (in_ch.action),
    .in_mem_address (in_ch.mem_address),
    .in_byte_value  (in_ch.byte_value),
    .in_reg_select  (in_ch.reg_select),
    .next_pc        (out_ch.next_pc),
    .executed_word  (out_ch.executed_word),
    .halted         (out_ch.halted),
    .reg_written    (out_ch.reg_written),
    .dest_reg       (out_ch.dest_reg),
    .dest_value     (out_ch.dest_value),
    .read_value     (out_ch.read_value)
  );

  // A word is never taken while a result is pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ch.ready && out_ch.valid))
    else $error("input accepted while result pending");

  // Once halted, the core stays halted.
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.halted) |=> (!out_ch.valid || out_ch.halted))
    else $error("halt flag cleared");

  // Register 0 is never reported as written.
  a_r0: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.reg_written) |-> (out_ch.dest_reg != 5'd0))
    else $error("write to register zero reported");

endmodule

// ===== verif/tb_mips_subset_single_cycle_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MIPS subset core regression
// Loads small programs byte by byte, steps them and reads back registers and
// data, comparing every result word with an in-bench model of the core.
// ----------------------------------------------------------------------------
module tb_mips_subset_single_cycle_core;

  localparam int unsigned MemSize = 65536;
  localparam int unsigned IdleLimit = 20000;

  typedef struct packed {
    logic [31:0] next_pc;
    logic [31:0] executed_word;
    logic        halted;
    logic        reg_written;
    logic [4:0]  dest_reg;
    logic [31:0] dest_value;
    logic [31:0] read_value;
  } core_result_t;

  class core_scoreboard;
    logic [31:0] regs [32];
    logic [7:0]  imem [MemSize];
    logic [7:0]  dmem [MemSize];
    logic [31:0] pc;
    logic [31:0] alu_last;
    logic        halt;
    core_result_t pending [$];
    int errors;
    int checked;

    function new();
      foreach (regs[i]) regs[i] = '0;
      pc = '0;
      alu_last = '0;
      halt = 1'b0;
      errors = 0;
      checked = 0;
    endfunction

    function logic [31:0] fetch_word(bit data_side, logic [31:0] base);
      logic [31:0] w;
      w = '0;
      for (int i = 0; i < 4; i++)
        w = {w[23:0], data_side ? dmem[(base + i) % MemSize] : imem[(base + i) % MemSize]};
      return w;
    endfunction

    function logic [31:0] run_alu(logic [2:0] op, logic [31:0] a, logic [31:0] b);
      case (op)
        msc_pkg::AluAddu: alu_last = a + b;
        msc_pkg::AluSubu: alu_last = a - b;
        msc_pkg::AluAnd:  alu_last = a & b;
        msc_pkg::AluOr:   alu_last = a | b;
        msc_pkg::AluXor:  alu_last = a ^ b;
        msc_pkg::AluNor:  alu_last = ~(a | b);
        default: ;
      endcase
      return alu_last;
    endfunction

    function void execute_one(ref core_result_t r);
      logic [31:0] ins, imm, pc4, a, b, res, val, addr;
      logic [5:0] opc;
      logic [4:0] dest;
      logic [2:0] op;
      logic itype, wen;
      if (halt) return;
      ins = fetch_word(1'b0, pc);
      r.executed_word = ins;
      if (ins == msc_pkg::HaltWord) begin
        halt = 1'b1;
        return;
      end
      opc = ins[31:26];
      imm = {{16{ins[15]}}, ins[15:0]};
      pc4 = pc + 32'd4;
      if (opc == msc_pkg::OpJump) begin
        pc = {pc4[31:28], ins[25:0], 2'b00};
        return;
      end
      itype = (opc != msc_pkg::OpRtype) && (opc[5:1] != msc_pkg::OpRtHi);
      a = regs[ins[25:21]];
      b = regs[ins[20:16]];
      if (opc == msc_pkg::OpLw || opc == msc_pkg::OpSw) op = msc_pkg::AluAddu;
      else if (opc == msc_pkg::OpRtype) op = ins[2:0];
      else op = opc[2:0];
      pc = (opc == msc_pkg::OpBeq && a == b) ? pc4 + (imm << 2) : pc4;
      res = run_alu(op, a, itype ? imm : b);
      if (itype) begin
        wen = !(opc == msc_pkg::OpSw || opc == msc_pkg::OpBeq);
        dest = ins[20:16];
        val = (opc == msc_pkg::OpLw) ? fetch_word(1'b1, res) : res;
        if (opc == msc_pkg::OpSw)
          for (int i = 0; i < 4; i++) begin
            addr = (res + i) % MemSize;
            dmem[addr] = b[31 - 8 * i -: 8];
          end
      end else begin
        wen = 1'b1;
        dest = ins[15:11];
        val = res;
      end
      if (wen && dest != 5'd0) begin
        regs[dest] = val;
        r.reg_written = 1'b1;
        r.dest_reg = dest;
        r.dest_value = val;
      end
    endfunction

    function void note_word(logic [2:0] act, logic [15:0] addr, logic [7:0] bv,
                            logic [4:0] sel);
      core_result_t r;
      r = '0;
      case (act)
        msc_pkg::ACT_LOAD_INSTR: imem[addr] = bv;
        msc_pkg::ACT_LOAD_DATA:  dmem[addr] = bv;
        msc_pkg::ACT_STEP:       execute_one(r);
        msc_pkg::ACT_READ_REG:   r.read_value = regs[sel];
        msc_pkg::ACT_READ_DATA:  r.read_value = {24'd0, dmem[addr]};
        default: ;
      endcase
      r.next_pc = pc;
      r.halted = halt;
      pending.push_back(r);
    endfunction

    function void check_result(core_result_t got);
      core_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word, actual %p", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got !== want) begin
        $display("%0t: result mismatch, expected %p, actual %p", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int send_idle_pct;
  int recv_idle_pct;
  int idle_cycles;
  int steps_sent;
  core_scoreboard board;
  logic [15:0] data_written [$];
  bit data_seen [MemSize];

  msc_in_if in_ch ();
  msc_out_if out_ch ();

  mips_subset_single_cycle_core DUT (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Receiver: randomly stalls ready and checks each accepted result word.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready)
        board.check_result({out_ch.next_pc, out_ch.executed_word, out_ch.halted,
                            out_ch.reg_written, out_ch.dest_reg, out_ch.dest_value,
                            out_ch.read_value});
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    if (idle_cycles >= IdleLimit) begin
      $display("Watchdog expired after %0d idle cycles", idle_cycles);
      $display("mips_subset_single_cycle_core regression: fail");
      $finish;
    end
  end

  // Valid stays high from one accepted word to the next unless the sender idles.
  task automatic send_word(logic [2:0] act, logic [15:0] addr, logic [7:0] bv,
                           logic [4:0] sel);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.mem_address <= addr;
    in_ch.byte_value <= bv;
    in_ch.reg_select <= sel;
    do @(posedge clk); while (!in_ch.ready);
    board.note_word(act, addr, bv, sel);
    if (act == msc_pkg::ACT_LOAD_DATA && !data_seen[addr]) begin
      data_seen[addr] = 1'b1;
      data_written.push_back(addr);
    end
    if (act == msc_pkg::ACT_STEP) steps_sent++;
  endtask

  task automatic load_instr(logic [15:0] addr, logic [31:0] w);
    for (int i = 0; i < 4; i++)
      send_word(msc_pkg::ACT_LOAD_INSTR, 16'(addr + i), w[31 - 8 * i -: 8], 5'($urandom));
  endtask

  task automatic load_data(logic [15:0] addr, logic [31:0] w);
    for (int i = 0; i < 4; i++)
      send_word(msc_pkg::ACT_LOAD_DATA, 16'(addr + i), w[31 - 8 * i -: 8], 5'($urandom));
  endtask

  // Builds a random instruction; the lw and sw of its load/store case hit preloaded bytes.
  function automatic logic [31:0] random_instr(logic [15:0] base);
    logic [5:0] opc;
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(9))
      0, 1, 2: begin
        w[31:26] = msc_pkg::OpRtype;
        w[2:0] = 3'($urandom);
      end
      3, 4: begin
        opc = 6'($urandom);
        if (opc == msc_pkg::OpJump || opc == msc_pkg::OpLw || opc == msc_pkg::OpBeq)
          opc = 6'b001101;
        w[31:26] = opc;
      end
      5: w[31:26] = {msc_pkg::OpRtHi, 1'b1};
      6: begin
        // Jump to the start of the program to keep execution in loaded memory.
        w = {msc_pkg::OpJump, 12'd0, base[15:2]};
      end
      7: begin
        w[31:26] = msc_pkg::OpBeq;
        w[15:0] = $urandom_range(1) ? 16'hFFFF : 16'd0;
      end
      default: begin
        w[31:26] = ($urandom_range(1)) ? msc_pkg::OpLw : msc_pkg::OpSw;
        w[25:21] = 5'd0;
        w[15:0] = 16'h8000 + 16'($urandom_range(60));
      end
    endcase
    return w;
  endfunction

  task automatic run_program(int len);
    logic [15:0] base;
    base = 16'($urandom_range(500)) << 4;
    if (board.pc != base || board.halt) begin
      // Only a fresh program at address zero or a jump reaches a new base.
      base = board.pc[15:0];
    end
    for (int i = 0; i < len; i++)
      load_instr(16'(base + 4 * i),
                 (i == len - 1) ? {msc_pkg::OpJump, 12'd0, base[15:2]} : random_instr(base));
    for (int i = 0; i < 3 * len; i++) begin
      send_word(msc_pkg::ACT_STEP, 16'($urandom), 8'($urandom), 5'($urandom));
      if ($urandom_range(3) == 0)
        send_word(msc_pkg::ACT_READ_REG, 16'($urandom), 8'($urandom), 5'($urandom));
    end
  endtask

  task automatic run_phase(int words);
    for (int i = 0; i < words / 40; i++) begin
      run_program($urandom_range(3, 8));
      if (data_written.size() != 0)
        send_word(msc_pkg::ACT_READ_DATA,
                  data_written[$urandom_range(data_written.size() - 1)],
                  8'($urandom), 5'($urandom));
      send_word(3'($urandom_range(5, 7)), 16'($urandom), 8'($urandom), 5'($urandom));
    end
  endtask

  initial begin
    board = new();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    steps_sent = 0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.action = '0;
    in_ch.mem_address = '0;
    in_ch.byte_value = '0;
    in_ch.reg_select = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Data window used by lw and sw, plus the top and bottom of data memory.
    for (int i = 0; i < 64; i += 4) load_data(16'(16'h8000 + i), $urandom);
    load_data(16'hFFFC, 32'hFFFF_FF00);
    load_data(16'h0000, 32'h0000_00FF);
    send_word(msc_pkg::ACT_READ_DATA, 16'hFFFF, 8'd0, 5'd0);
    send_word(msc_pkg::ACT_READ_REG, 16'd0, 8'd0, 5'd31);

    // Directed program: addiu-style ori with negative immediate, nor, subu,
    // lw across the wrap of data memory, sw, beq taken, unsupported op reuse.
    load_instr(16'd0,  {6'b001101, 5'd0, 5'd1, 16'hFFFF});
    load_instr(16'd4,  {msc_pkg::OpRtype, 5'd1, 5'd0, 5'd2, 5'd0, 6'b100111});
    load_instr(16'd8,  {msc_pkg::OpRtype, 5'd0, 5'd1, 5'd3, 5'd0, 6'b100011});
    load_instr(16'd12, {msc_pkg::OpLw, 5'd0, 5'd4, 16'hFFFE});
    load_instr(16'd16, {msc_pkg::OpSw, 5'd0, 5'd1, 16'h8000});
    load_instr(16'd20, {msc_pkg::OpRtype, 5'd1, 5'd1, 5'd0, 5'd0, 6'b100001});
    load_instr(16'd24, {msc_pkg::OpRtype, 5'd1, 5'd2, 5'd5, 5'd0, 6'b000000});
    load_instr(16'd28, {msc_pkg::OpBeq, 5'd0, 5'd0, 16'd0});
    load_instr(16'd32, {msc_pkg::OpJump, 26'd0});
    repeat (9) send_word(msc_pkg::ACT_STEP, 16'd0, 8'd0, 5'd0);
    for (int r = 0; r < 6; r++) send_word(msc_pkg::ACT_READ_REG, 16'd0, 8'd0, 5'(r));
    send_word(msc_pkg::ACT_READ_DATA, 16'h8003, 8'd0, 5'd0);

    send_idle_pct = 27;
    recv_idle_pct = 76;
    run_phase(140);
    send_idle_pct = 76;
    recv_idle_pct = 27;
    run_phase(140);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(140);

    // Halt: place the halt word at the current PC, step twice, and read back.
    load_instr(board.pc[15:0], msc_pkg::HaltWord);
    repeat (2) send_word(msc_pkg::ACT_STEP, 16'd0, 8'd0, 5'd0);
    send_word(msc_pkg::ACT_READ_REG, 16'd0, 8'd0, 5'd1);
    in_ch.valid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    $display("Checked %0d result words, %0d of them from instruction steps.",
             board.checked, steps_sent);
    $display("Covered byte loads, reads, R and I forms, lw/sw, beq, j and halt.");
    if (board.errors == 0 && board.pending.size() == 0)
      $display("mips_subset_single_cycle_core regression: pass");
    else
      $display("mips_subset_single_cycle_core regression: fail");
    $finish;
  end
endmodule
